>>> hdl/stochastic_rsi_oscillator_macros.svh
// assertion macros for the stochastic rsi oscillator
// used by the top level; needs clk_i and rst_ni in the including scope
`ifndef STOCHASTIC_RSI_OSCILLATOR_MACROS_SVH
`define STOCHASTIC_RSI_OSCILLATOR_MACROS_SVH

// combinational property checked on every edge outside reset
`define SRSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent on this edge implies consequent on the next
`define SRSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/srsi_pkg.sv
// shared types and constants of the stochastic rsi oscillator
// no dependencies
`default_nettype none
package srsi_pkg;

  localparam int unsigned PRICE_W      = 32;
  localparam int unsigned PERIOD_W     = 7;
  localparam int unsigned SUM_W        = 48;
  localparam int unsigned RSI_W        = 17;
  localparam int unsigned DIVD_W       = 64;
  localparam int unsigned DIVS_W       = 49;
  localparam int unsigned PERIOD_MAX_DEF = 64;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd14;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 7'd2;
  localparam logic [RSI_W-1:0]    ONE_Q16      = 17'd65536;

  typedef struct packed {
    logic busy;
    logic done;
  } srsi_div_sts_t;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_PREP   = 13'b0000000000010,
    S_AVG_UP = 13'b0000000000100,
    S_AVG_DN = 13'b0000000001000,
    S_WIL_UP = 13'b0000000010000,
    S_WIL_DN = 13'b0000000100000,
    S_RSI    = 13'b0000001000000,
    S_INIT   = 13'b0000010000000,
    S_UPD    = 13'b0000100000000,
    S_SCAN   = 13'b0001000000000,
    S_WR     = 13'b0010000000000,
    S_OUT    = 13'b0100000000000,
    S_EMIT   = 13'b1000000000000
  } srsi_state_e;

endpackage
`default_nettype wire

>>> hdl/srsi_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module srsi_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> hdl/srsi_div.sv
// restoring divider, one quotient bit a cycle
// depends on srsi_pkg for the status struct
`default_nettype none
module srsi_div
  import srsi_pkg::*;
#(
  parameter int unsigned DW = 64,
  parameter int unsigned VW = 49
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output srsi_div_sts_t      sts_o,
  output logic      [DW-1:0] quot_o
);

  localparam int unsigned CNTW = $clog2(DW + 1);

  logic [DW-1:0]   num_q;
  logic [VW-1:0]   den_q;
  logic [VW:0]     rem_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [VW:0]     trial;
  logic            fits;

  assign trial = {rem_q[VW-1:0], num_q[DW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      quot_o <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        num_q  <= dividend_i;
        den_q  <= divisor_i;
        rem_q  <= '0;
        quot_o <= '0;
        cnt_q  <= CNTW'(DW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q  <= fits ? trial - {1'b0, den_q} : trial;
        num_q  <= {num_q[DW-2:0], 1'b0};
        quot_o <= {quot_o[DW-2:0], fits};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule
`default_nettype wire

>>> hdl/stochastic_rsi_oscillator.sv
// stochastic rsi oscillator top level: sequencer, smoothing state, window tracking
// depends on srsi_pkg, srsi_ram, srsi_div and the assertion macros
//
//  channel   dir  fields (low bit up)                 handshake
//  s_axis    in   tdata: price[31:0]; tuser: new_series  tvalid/tready
//  m_axis    out  tdata: stoch_value[16:0], zero pad     tvalid/tready
//  cfg       in   cfg_data_i: period[6:0]              cfg_valid_i/cfg_ready_o
//
// warm-up samples only add to the sums, the averaging sample divides them; once
// running a sample runs the divider for both wilder steps and the rsi (skipped
// when the up sum is zero), scans the ring when an extreme leaves the window
// and divides out any output word that is not zero. the divider is shared
// and makes one quotient bit a cycle; the ring scan reads one entry a cycle.
// reset is immediate, no clearing pass. a new sample is taken while an output
// word waits; only the next output word stalls on m_axis_tready.
`default_nettype none
`include "stochastic_rsi_oscillator_macros.svh"
module stochastic_rsi_oscillator
  import srsi_pkg::*;
#(
  parameter int unsigned PERIOD_MAX = PERIOD_MAX_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [31:0]         s_axis_tdata,   // price[31:0]
  input  wire logic [0:0]          s_axis_tuser,   // new_series[0]
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [23:0]         m_axis_tdata,   // stoch_value[16:0], zeros above
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [PERIOD_W-1:0] cfg_data_i
);

  localparam int unsigned PW = (PERIOD_MAX > 1) ? $clog2(PERIOD_MAX) : 1;
  localparam int unsigned SW = $clog2(PERIOD_MAX + 1);
  localparam int unsigned CW = $clog2(2 * PERIOD_MAX + 1);
  localparam int unsigned KW = CW + 8;

  srsi_state_e         state_q;
  logic                go_q;
  logic [PERIOD_W-1:0] period_q, eff_p;
  logic [PRICE_W-1:0]  price_q, prev_q;
  logic [CW-1:0]       cnt_q;
  logic [SUM_W-1:0]    up_q, dn_q;
  logic [PW-1:0]       pos_q, maxs_q, mins_q;
  logic [RSI_W-1:0]    max_q, min_q, r_q, res_q;
  logic                scan_max_q, scan_min_q, rvld_q;
  logic [SW-1:0]       saddr_q;
  logic [PW-1:0]       ridx_q;
  logic                mval_q;
  logic [RSI_W-1:0]    mdata_q;

  logic [KW-1:0]       idx_k, p_k, pos_k;
  logic [PRICE_W-1:0]  up_mv, dn_mv;
  logic [SUM_W-1:0]    mvx;
  logic [SUM_W:0]      diff, mag;
  logic                div_start;
  logic [DIVD_W-1:0]   div_num, quot;
  logic [DIVS_W-1:0]   div_den;
  srsi_div_sts_t       div_sts;
  logic [SUM_W-1:0]    q48, avg_sat;
  logic [RSI_W-1:0]    q17;
  logic                ram_we;
  logic [PW-1:0]       ram_waddr;
  logic [RSI_W-1:0]    ram_rdata;
  logic                ram_re;
  logic                accept;
  logic [CW-1:0]       cnt_next;
  logic                out_nz, out_free, out_load;
  logic [RSI_W-1:0]    out_word;

  // period clamped to the supported range
  always_comb begin
    eff_p = period_q;
    if (period_q < PERIOD_MIN) eff_p = PERIOD_MIN;
    if ({{(KW-PERIOD_W){1'b0}}, period_q} > KW'(PERIOD_MAX)) eff_p = PERIOD_W'(PERIOD_MAX);
  end

  assign idx_k = KW'(cnt_q);
  assign p_k   = KW'(eff_p);
  assign pos_k = KW'(pos_q);

  always_comb begin
    up_mv = '0;
    dn_mv = '0;
    if (cnt_q != '0) begin
      if (price_q > prev_q) up_mv = price_q - prev_q;
      else                  dn_mv = prev_q - price_q;
    end
  end

  // wilder step works on the magnitude, sign restored afterwards
  always_comb begin
    mvx  = (state_q == S_WIL_UP) ? {up_mv, 16'h0} : {dn_mv, 16'h0};
    diff = {1'b0, mvx} - ((state_q == S_WIL_UP) ? {1'b0, up_q} : {1'b0, dn_q});
    mag  = diff[SUM_W] ? -diff : diff;
  end

  always_comb begin
    div_num = '0;
    div_den = DIVS_W'(eff_p);
    unique case (state_q)
      S_AVG_UP: div_num = {up_q, 16'h0};
      S_AVG_DN: div_num = {dn_q, 16'h0};
      S_WIL_UP, S_WIL_DN: div_num = DIVD_W'(mag);
      S_RSI: begin
        div_num = {up_q, 16'h0};
        div_den = {1'b0, up_q} + {1'b0, dn_q};
      end
      S_OUT: begin
        div_num = DIVD_W'({r_q - min_q, 16'h0});
        div_den = DIVS_W'(max_q - min_q);
      end
      default: ;
    endcase
  end

  assign out_nz = (max_q > min_q) && (r_q >= min_q);

  assign div_start = !go_q && ((state_q == S_AVG_UP) || (state_q == S_AVG_DN)
                  || (state_q == S_WIL_UP) || (state_q == S_WIL_DN)
                  || ((state_q == S_RSI) && (up_q != '0))
                  || ((state_q == S_OUT) && out_nz));

  srsi_div #(.DW(DIVD_W), .VW(DIVS_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .sts_o      (div_sts),
    .quot_o     (quot)
  );

  assign q48     = quot[SUM_W-1:0];
  assign avg_sat = (quot[DIVD_W-1:SUM_W] != '0) ? '1 : q48;
  assign q17     = ((quot[DIVD_W-1:RSI_W] != '0) || (quot[RSI_W-1:0] > ONE_Q16))
                   ? ONE_Q16 : quot[RSI_W-1:0];

  // output word loads only when the register is free or being drained
  always_comb begin
    out_free = !mval_q || m_axis_tready;
    out_load = 1'b0;
    out_word = res_q;
    if (state_q == S_OUT) begin
      if (!out_nz) begin
        out_load = out_free;
        out_word = '0;
      end else if (div_sts.done) begin
        out_load = out_free;
        out_word = q17;
      end else if (go_q && !div_sts.busy) begin
        out_load = out_free;
      end
    end
  end

  assign ram_we    = (state_q == S_INIT) || (state_q == S_WR);
  assign ram_waddr = (state_q == S_INIT) ? '0 : pos_q;
  assign ram_re    = (state_q == S_SCAN) && (KW'(saddr_q) < p_k);

  srsi_ram #(.WIDTH(RSI_W), .DEPTH(PERIOD_MAX)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (r_q),
    .re_i    (ram_re),
    .raddr_i (saddr_q[PW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign cnt_next = (idx_k + KW'(1) >= (p_k << 1)) ? CW'(p_k << 1) : cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      go_q       <= 1'b0;
      period_q   <= PERIOD_RESET;
      price_q    <= '0;
      prev_q     <= '0;
      cnt_q      <= '0;
      up_q       <= '0;
      dn_q       <= '0;
      pos_q      <= '0;
      maxs_q     <= '0;
      mins_q     <= '0;
      max_q      <= '0;
      min_q      <= '0;
      r_q        <= '0;
      res_q      <= '0;
      scan_max_q <= 1'b0;
      scan_min_q <= 1'b0;
      rvld_q     <= 1'b0;
      saddr_q    <= '0;
      ridx_q     <= '0;
      mval_q     <= 1'b0;
      mdata_q    <= '0;
    end else begin
      if (cfg_valid_i) period_q <= cfg_data_i;
      if (out_load) begin
        mval_q  <= 1'b1;
        mdata_q <= out_word;
      end else if (m_axis_tready) begin
        mval_q <= 1'b0;
      end
      if (div_start) go_q <= 1'b1;

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            price_q <= s_axis_tdata;
            if (s_axis_tuser[0]) begin
              prev_q <= '0; cnt_q <= '0; up_q <= '0; dn_q <= '0;
              pos_q <= '0; maxs_q <= '0; mins_q <= '0; max_q <= '0; min_q <= '0;
            end
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          if (cnt_q == '0) begin
            state_q <= S_EMIT;
          end else if (idx_k <= p_k) begin
            up_q <= up_q + SUM_W'(up_mv);
            dn_q <= dn_q + SUM_W'(dn_mv);
            state_q <= (idx_k == p_k) ? S_AVG_UP : S_EMIT;
          end else begin
            state_q <= S_WIL_UP;
          end
        end
        S_AVG_UP, S_AVG_DN: begin
          if (div_sts.done) begin
            go_q <= 1'b0;
            if (state_q == S_AVG_UP) begin
              up_q <= avg_sat; state_q <= S_AVG_DN;
            end else begin
              dn_q <= avg_sat; state_q <= S_RSI;
            end
          end
        end
        S_WIL_UP, S_WIL_DN: begin
          if (div_sts.done) begin
            go_q <= 1'b0;
            if (state_q == S_WIL_UP) begin
              up_q <= diff[SUM_W] ? up_q - q48 : up_q + q48; state_q <= S_WIL_DN;
            end else begin
              dn_q <= diff[SUM_W] ? dn_q - q48 : dn_q + q48; state_q <= S_RSI;
            end
          end
        end
        S_RSI: begin
          if (up_q == '0) begin
            r_q <= '0;
            state_q <= (idx_k == p_k) ? S_INIT : S_UPD;
          end else if (div_sts.done) begin
            go_q <= 1'b0;
            r_q <= q17;
            state_q <= (idx_k == p_k) ? S_INIT : S_UPD;
          end
        end
        S_INIT: begin
          pos_q <= PW'(1);
          max_q <= r_q; min_q <= r_q;
          maxs_q <= '0; mins_q <= '0;
          state_q <= S_EMIT;
        end
        S_UPD: begin
          logic [PW-1:0] pos;
          logic          smax, smin;
          pos  = (pos_k >= p_k) ? '0 : pos_q;
          smax = !(r_q > max_q) && (maxs_q == pos);
          smin = !(r_q < min_q) && (mins_q == pos);
          pos_q <= pos;
          if (r_q > max_q) begin
            max_q <= r_q; maxs_q <= pos;
          end else if (smax) begin
            max_q <= r_q;
          end
          if (r_q < min_q) begin
            min_q <= r_q; mins_q <= pos;
          end else if (smin) begin
            min_q <= r_q;
          end
          scan_max_q <= smax;
          scan_min_q <= smin;
          saddr_q    <= '0;
          rvld_q     <= 1'b0;
          state_q    <= (smax || smin) ? S_SCAN : S_WR;
        end
        S_SCAN: begin
          rvld_q <= ram_re;
          ridx_q <= saddr_q[PW-1:0];
          if (ram_re) saddr_q <= saddr_q + 1'b1;
          if (rvld_q && (ridx_q != pos_q)) begin
            if (scan_max_q && (ram_rdata > max_q)) begin
              max_q <= ram_rdata; maxs_q <= ridx_q;
            end
            if (scan_min_q && (ram_rdata < min_q)) begin
              min_q <= ram_rdata; mins_q <= ridx_q;
            end
          end
          if (!ram_re && !rvld_q) state_q <= S_WR;
        end
        S_WR: begin
          pos_q <= (pos_k + KW'(1) >= p_k) ? '0 : pos_q + 1'b1;
          state_q <= (idx_k + KW'(1) >= (p_k << 1)) ? S_OUT : S_EMIT;
        end
        S_OUT: begin
          // go stays high after the quotient lands so the divider is not restarted
          if (div_sts.done) res_q <= q17;
          if (out_load) state_q <= S_EMIT;
        end
        S_EMIT: begin
          go_q    <= 1'b0;
          prev_q  <= price_q;
          cnt_q   <= cnt_next;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = {7'h0, mdata_q};

  `SRSI_ASSERT(a_out_range, !m_axis_tvalid || (m_axis_tdata[16:0] <= ONE_Q16), "output above one")
  `SRSI_ASSERT(a_min_le_max, (state_q != S_IDLE) || (min_q <= max_q), "window min above max")
  `SRSI_ASSERT(a_div_free, !div_start || !div_sts.busy, "divider started while busy")
  `SRSI_ASSERT_NEXT(a_scan_ends, (state_q == S_SCAN) && !ram_re && !rvld_q,
                    state_q == S_WR, "ring scan did not hand over to write back")

endmodule
`default_nettype wire

>>> sim/tb_stochastic_rsi_oscillator.sv
// self-checking testbench for the stochastic rsi oscillator
// depends on srsi_pkg and the stochastic_rsi_oscillator top level
`default_nettype none
module tb_stochastic_rsi_oscillator;
  import srsi_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata = '0;   // price[31:0]
  logic [0:0]          s_axis_tuser = '0;   // new_series[0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;        // stoch_value[16:0], zeros above
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [PERIOD_W-1:0] cfg_data_i = '0;

  stochastic_rsi_oscillator DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  localparam int unsigned SETTLE_CYCLES = 800;
  localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

  // predictor state
  logic [PERIOD_W-1:0] osc_period;
  logic [31:0]         osc_prev_price;
  int unsigned         osc_count;
  logic [47:0]         osc_up, osc_down;
  logic [RSI_W-1:0]    osc_ring [64];
  int unsigned         osc_pos, osc_max_slot, osc_min_slot;
  logic [RSI_W-1:0]    osc_max, osc_min;

  logic [RSI_W-1:0] expected_stoch [$];
  int unsigned      mismatches = 0;
  int unsigned      items_sent = 0;
  bit               burst_mode = 1'b0;
  logic [31:0]      walk_price = 32'h0010_0000;

  function automatic void clear_series();
    osc_prev_price = '0;
    osc_count = 0;
    osc_up = '0;
    osc_down = '0;
    foreach (osc_ring[i]) osc_ring[i] = '0;
    osc_pos = 0;
    osc_max = '0;
    osc_min = '0;
    osc_max_slot = 0;
    osc_min_slot = 0;
  endfunction

  function automatic logic [47:0] wilder_step(logic [47:0] s, logic [31:0] mv, int unsigned p);
    longint x, cur, n;
    x = longint'(mv) <<< 16;
    cur = longint'({16'b0, s});
    n = cur + (x - cur) / longint'(p);
    if (n < 0) n = 0;
    return n[47:0];
  endfunction

  function automatic logic [47:0] average_sum(logic [47:0] sum, int unsigned p);
    logic [63:0] a;
    a = ({16'b0, sum} << 16) / 64'(p);
    return (a > 64'(MASK48)) ? MASK48 : a[47:0];
  endfunction

  function automatic logic [RSI_W-1:0] rsi_fraction(logic [47:0] up, logic [47:0] down);
    logic [63:0] r;
    if (up == 0) return '0;
    r = ({16'b0, up} << 16) / (64'(up) + 64'(down));
    return (r > 64'(ONE_Q16)) ? ONE_Q16 : r[RSI_W-1:0];
  endfunction

  // advances the predictor by one accepted sample, queues the word it yields
  function automatic void predict_sample(logic [31:0] price, logic ns);
    int unsigned p, idx, pos;
    logic [31:0] up_mv, dn_mv;
    logic [RSI_W-1:0] r;
    logic [63:0] v;
    p = osc_period < PERIOD_MIN ? 2 : (osc_period > 64 ? 64 : osc_period);
    if (ns) clear_series();
    idx = osc_count;
    up_mv = '0;
    dn_mv = '0;
    if (idx > 0) begin
      if (price > osc_prev_price) up_mv = price - osc_prev_price;
      else dn_mv = osc_prev_price - price;
    end
    if (idx == 0) begin
    end else if (idx <= p) begin
      osc_up = osc_up + up_mv;
      osc_down = osc_down + dn_mv;
      if (idx == p) begin
        osc_up = average_sum(osc_up, p);
        osc_down = average_sum(osc_down, p);
        r = rsi_fraction(osc_up, osc_down);
        osc_ring[0] = r;
        osc_pos = 1;
        osc_max = r;
        osc_min = r;
        osc_max_slot = 0;
        osc_min_slot = 0;
      end
    end else begin
      osc_up = wilder_step(osc_up, up_mv, p);
      osc_down = wilder_step(osc_down, dn_mv, p);
      r = rsi_fraction(osc_up, osc_down);
      pos = (osc_pos >= p) ? 0 : osc_pos;
      // extreme leaving the window forces a rescan
      if (r > osc_max) begin
        osc_max = r;
        osc_max_slot = pos;
      end else if (osc_max_slot == pos) begin
        osc_max = r;
        for (int j = 0; j < p; j++)
          if (j != pos && osc_ring[j] > osc_max) begin
            osc_max = osc_ring[j];
            osc_max_slot = j;
          end
      end
      if (r < osc_min) begin
        osc_min = r;
        osc_min_slot = pos;
      end else if (osc_min_slot == pos) begin
        osc_min = r;
        for (int j = 0; j < p; j++)
          if (j != pos && osc_ring[j] < osc_min) begin
            osc_min = osc_ring[j];
            osc_min_slot = j;
          end
      end
      osc_ring[pos] = r;
      osc_pos = (pos + 1 >= p) ? 0 : pos + 1;
      if (idx >= 2 * p - 1) begin
        v = '0;
        if (osc_max > osc_min && r >= osc_min) begin
          v = (64'(r - osc_min) << 16) / 64'(osc_max - osc_min);
          if (v > 64'(ONE_Q16)) v = 64'(ONE_Q16);
        end
        expected_stoch.push_back(v[RSI_W-1:0]);
      end
    end
    osc_prev_price = price;
    osc_count = (idx + 1 >= 2 * p) ? 2 * p : idx + 1;
  endfunction

  task automatic send_price(logic [31:0] price, logic ns);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= price;
    s_axis_tuser <= ns;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_sample(price, ns);
    items_sent++;
  endtask

  // only written once every word is out and the last sample has settled
  task automatic write_period(logic [PERIOD_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (expected_stoch.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    osc_period = value;
  endtask

  function automatic logic [31:0] next_walk();
    int unsigned k;
    logic [31:0] d;
    k = $urandom_range(0, 31);
    d = 32'($urandom() & ((33'd1 << k) - 33'd1));
    case ($urandom_range(0, 9))
      0: walk_price = $urandom();
      1: ;  // flat step
      2, 3, 4, 5: walk_price = walk_price + d;
      default: walk_price = walk_price - d;
    endcase
    return walk_price;
  endfunction

  task automatic run_series(int unsigned len);
    send_price(next_walk(), 1'b1);
    for (int i = 1; i < len; i++) send_price(next_walk(), ($urandom_range(0, 99) == 0));
  endtask

  // default period straight out of reset
  task automatic test_reset_period();
    osc_period = PERIOD_RESET;
    clear_series();
    for (int i = 0; i < 20; i++) send_price(32'h0001_0000 + 32'(i % 5) * 32'h0000_8000, 1'b0);
  endtask

  // field extremes, flat prices, pure rises and falls at the shortest period
  task automatic test_extremes();
    write_period(7'd2);
    send_price(32'h0000_0000, 1'b1);
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'h0000_0000, 1'b0);
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'h8000_0000, 1'b0);
    send_price(32'h0000_0001, 1'b0);
    send_price(32'h5555_5555, 1'b1);
    for (int i = 0; i < 5; i++) send_price(32'h5555_5555, 1'b0);
    send_price(32'h0000_0010, 1'b1);
    for (int i = 1; i < 6; i++) send_price(32'h0000_0010 + 32'(i), 1'b0);
  endtask

  // out-of-range periods clamp to the legal range
  task automatic test_clamped_periods();
    write_period(7'd0);
    run_series(8);
    write_period(7'd1);
    run_series(8);
    write_period(7'd127);
    run_series(140);
  endtask

  task automatic test_longest_window();
    write_period(7'd64);
    run_series(150);
  endtask

  task automatic test_random();
    while (items_sent < 750) begin
      if ($urandom_range(0, 4) == 0) write_period(7'($urandom_range(0, 127)));
      else write_period(7'($urandom_range(2, 8)));
      burst_mode = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) run_series($urandom_range(10, 60));
      burst_mode = 1'b0;
    end
  endtask

  // result side: stall a random number of cycles before each word
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    logic [RSI_W-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_stoch.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: stoch_value %0d", m_axis_tdata[16:0]);
      end else begin
        want = expected_stoch.pop_front();
        if (m_axis_tdata[16:0] !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("stoch_value mismatch: expected %0d actual %0d", want,
                     m_axis_tdata[16:0]);
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_period();
    test_extremes();
    test_clamped_periods();
    test_longest_window();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (expected_stoch.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    mismatches += expected_stoch.size();
    if (mismatches == 0) $display("tb_stochastic_rsi_oscillator passed");
    else $display("tb_stochastic_rsi_oscillator failed");
    $finish;
  end

  initial begin
    #120_000_000;
    $display("tb_stochastic_rsi_oscillator failed");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
+incdir+hdl
hdl/srsi_pkg.sv
hdl/srsi_ram.sv
hdl/srsi_div.sv
hdl/stochastic_rsi_oscillator.sv
sim/tb_stochastic_rsi_oscillator.sv
